@@ sv/rational_arithmetic_unit_macros.svh @@
// ---------------------------------------------------------------------------
// rational arithmetic unit assertion macros
// shared property shorthands for the rtl
// ---------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// implication checked every edge outside reset
`define RAU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rau check failed");

// next-cycle implication outside reset
`define RAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rau check failed");

`endif

@@ sv/rau_pkg.sv @@
// ---------------------------------------------------------------------------
// rational arithmetic unit package
// action and status codes and the default data width
// ---------------------------------------------------------------------------
package rau_pkg;
  localparam int DefWidth = 32;

  typedef enum logic [2:0] {
    ACT_NORM = 3'd0,
    ACT_ADD  = 3'd1,
    ACT_SUB  = 3'd2,
    ACT_MUL  = 3'd3,
    ACT_DIV  = 3'd4,
    ACT_CMP  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZDEN  = 2'd1,
    ST_DIVZ  = 2'd2,
    ST_OVFL  = 2'd3
  } status_t;
endpackage

@@ sv/rational_arithmetic_unit.sv @@
// ---------------------------------------------------------------------------
// rational arithmetic unit
// normalize, add, subtract, multiply, divide and compare of two fractions
// ---------------------------------------------------------------------------
// usage:
//   s_axis carries one transaction per operation: action and the two
//   fractions a and b. m_axis returns the reduced result, the compare
//   outcome and a status code.
//   s_axis_tready is high only while the unit is idle; one transaction is
//   worked at a time. A zero denominator takes the shortest path; the
//   work of the others falls on one shared 64-bit subtract/compare unit that
//   runs up to three binary gcd passes and up to six restoring divisions
//   (two per reduction), plus three multiply steps on a 32x32 multiplier.
//   The result sits in an output register until m_axis_tready; while it
//   waits no new transaction is taken, and the next one can be taken the cycle
//   after the result transaction.
//   rst (synchronous, active high) drops m_axis_tvalid and returns to idle.
//   A zero denominator gives status 1, a zero divisor status 2, a reduced
//   result part above 2^(WIDTH-1)-1 status 3; those and compare give 0/1.
// ---------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int WIDTH = rau_pkg::DefWidth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_num, a_den, b_num, b_den
  input  logic [127:0] s_axis_tdata,
  // action
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // res_num, res_den, order, status
  output logic [71:0]  m_axis_tdata
);
  import rau_pkg::*;
  `include "rational_arithmetic_unit_macros.svh"

  localparam int WEff = (WIDTH > 32) ? 32 : ((WIDTH < 2) ? 2 : WIDTH);
  localparam logic [63:0] Lim = (64'd1 << (WEff - 1)) - 64'd1;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_GINIT, S_GSTEP, S_DIVN, S_DIVD, S_DSTEP, S_DDONE,
    S_MUL, S_MULW, S_COMB, S_CHK, S_OUT
  } state_t;

  state_t      state;
  logic [2:0]  act;
  logic [31:0] in_an, in_ad, in_bn, in_bd;
  // fraction registers (sign, magnitude)
  logic        fa_neg, fb_neg, fr_neg;
  logic [63:0] fa_n, fa_d, fb_n, fb_d, fr_n, fr_d;
  logic [1:0]  which;     // 0 reduce a, 1 reduce b, 2 reduce result
  // gcd
  logic [63:0] gx, gy;
  logic [6:0]  gk;
  // divider
  logic [63:0] dq, drem, ddiv;
  logic [6:0]  dcnt;
  logic        dsel;      // 0 numerator, 1 denominator
  // multiplier
  logic [1:0]  mstep;
  logic [31:0] mx, my;
  logic [63:0] mprod, p0, p1, p2;
  logic [1:0]  ord;
  logic [1:0]  st;
  logic [31:0] onum;
  logic [30:0] oden;

  // shared subtractor
  logic [63:0] sub_a, sub_b, sub_r;
  logic        sub_ge;
  logic        gx_ge;
  logic [64:0] rem_sh;
  always_comb begin
    rem_sh = {drem, dq[63]};
    gx_ge  = gx >= gy;
    sub_a  = gx_ge ? gx : gy;
    sub_b  = gx_ge ? gy : gx;
    if (state == S_DSTEP) begin
      sub_a = rem_sh[63:0];
      sub_b = ddiv;
    end
    sub_r  = sub_a - sub_b;
    sub_ge = (state == S_DSTEP) ? (rem_sh >= {1'b0, ddiv}) : gx_ge;
  end

  function automatic logic [63:0] mag32(input logic [31:0] v);
    logic [31:0] t;
    t = v[31] ? (~v + 32'd1) : v;
    return {32'd0, t};
  endfunction

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign m_axis_tdata  = {5'd0, st, ord, oden, onum};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            act   <= (s_axis_tuser > 3'd5) ? ACT_NORM : s_axis_tuser;
            in_an <= s_axis_tdata[31:0];
            in_ad <= s_axis_tdata[63:32];
            in_bn <= s_axis_tdata[95:64];
            in_bd <= s_axis_tdata[127:96];
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          fa_neg <= in_an[31] ^ in_ad[31];
          fa_n   <= mag32(in_an);
          fa_d   <= mag32(in_ad);
          fb_neg <= in_bn[31] ^ in_bd[31];
          fb_n   <= mag32(in_bn);
          fb_d   <= mag32(in_bd);
          ord    <= 2'd0;
          if (in_ad == 32'd0 || (act != ACT_NORM && in_bd == 32'd0)) begin
            st    <= ST_ZDEN;
            state <= S_CHK;
            fr_n  <= 64'd0;
          end else begin
            st    <= ST_OK;
            which <= 2'd0;
            fr_neg <= 1'b0;
            fr_n  <= 64'd0;
            state <= S_GINIT;
          end
        end
        S_GINIT: begin
          // pick the fraction to reduce into fr
          if (which == 2'd0) begin
            fr_neg <= fa_neg; fr_n <= fa_n; fr_d <= fa_d;
            gx <= fa_n; gy <= fa_d;
          end else if (which == 2'd1) begin
            fr_neg <= fb_neg; fr_n <= fb_n; fr_d <= fb_d;
            gx <= fb_n; gy <= fb_d;
          end else begin
            gx <= fr_n; gy <= fr_d;
          end
          gk    <= 7'd0;
          state <= S_GSTEP;
        end
        S_GSTEP: begin
          // binary gcd, one step per cycle
          if (fr_n == 64'd0) begin
            // zero numerator: 0/1
            fr_neg <= 1'b0; fr_n <= 64'd0; fr_d <= 64'd1;
            state  <= S_DDONE;
          end else if (gx == 64'd0) begin
            gx    <= gy << gk[5:0];
            state <= S_DIVN;
          end else if (!gx[0] && !gy[0]) begin
            gx <= gx >> 1; gy <= gy >> 1; gk <= gk + 7'd1;
          end else if (!gx[0]) begin
            gx <= gx >> 1;
          end else if (!gy[0]) begin
            gy <= gy >> 1;
          end else if (sub_ge) begin
            gx <= sub_r >> 1;
          end else begin
            gy <= sub_r >> 1;
          end
        end
        S_DIVN: begin
          dq <= fr_n; drem <= 64'd0; ddiv <= gx; dcnt <= 7'd0; dsel <= 1'b0;
          state <= S_DSTEP;
        end
        S_DIVD: begin
          dq <= fr_d; drem <= 64'd0; dcnt <= 7'd0; dsel <= 1'b1;
          state <= S_DSTEP;
        end
        S_DSTEP: begin
          dq <= {dq[62:0], sub_ge};
          drem <= sub_ge ? sub_r : rem_sh[63:0];
          dcnt <= dcnt + 7'd1;
          if (dcnt == 7'd63) begin
            if (!dsel) begin
              fr_n  <= {dq[62:0], sub_ge};
              state <= S_DIVD;
            end else begin
              fr_d  <= {dq[62:0], sub_ge};
              state <= S_DDONE;
            end
          end
        end
        S_DDONE: begin
          if (which == 2'd0) begin
            fa_neg <= fr_neg; fa_n <= fr_n; fa_d <= fr_d;
            if (act == ACT_NORM) state <= S_CHK;
            else begin
              which <= 2'd1; state <= S_GINIT;
            end
          end else if (which == 2'd1) begin
            fb_neg <= fr_neg; fb_n <= fr_n; fb_d <= fr_d;
            if (act == ACT_DIV && fr_n == 64'd0) begin
              st <= ST_DIVZ; state <= S_CHK;
            end else begin
              mstep <= 2'd0; state <= S_MUL;
            end
          end else begin
            state <= S_CHK;
          end
        end
        S_MUL: begin
          // three products, one per pass through the multiplier
          unique case (mstep)
            2'd0: begin
              mx <= fa_n[31:0];
              my <= (act == ACT_MUL) ? fb_n[31:0] : fb_d[31:0];
            end
            2'd1: begin
              mx <= fb_n[31:0];
              my <= fa_d[31:0];
            end
            2'd2: begin
              mx <= fa_d[31:0];
              my <= (act == ACT_DIV) ? fb_n[31:0] : fb_d[31:0];
            end
            default: begin
              mx <= 32'd0;
              my <= 32'd0;
            end
          endcase
          state <= S_MULW;
        end
        S_MULW: begin
          unique case (mstep)
            2'd0:    p0 <= mprod;
            2'd1:    p1 <= mprod;
            2'd2:    p2 <= mprod;
            default: p0 <= p0;
          endcase
          if (mstep == 2'd2) state <= S_COMB;
          else begin
            mstep <= mstep + 2'd1; state <= S_MUL;
          end
        end
        S_COMB: begin
          unique case (act)
            ACT_ADD, ACT_SUB, ACT_CMP: begin
              // a.n*b.d +/- b.n*a.d in sign-magnitude
              logic bneg;
              bneg = ((act == ACT_ADD) ? fb_neg : !fb_neg) && (fb_n != 64'd0);
              if (act == ACT_CMP) begin
                state <= S_CHK;
                fr_n  <= 64'd0;
                if (fa_neg == bneg) begin
                  ord <= ((p0 | p1) == 64'd0) ? 2'd0 : (fa_neg ? 2'b11 : 2'b01);
                end else if (p0 == p1) ord <= 2'd0;
                else if (p0 > p1) ord <= fa_neg ? 2'b11 : 2'b01;
                else ord <= bneg ? 2'b11 : 2'b01;
              end else begin
                fr_d  <= p2;
                which <= 2'd2;
                state <= S_GINIT;
                if (fa_neg == bneg) begin
                  fr_neg <= fa_neg; fr_n <= p0 + p1;
                end else if (p0 >= p1) begin
                  fr_neg <= fa_neg; fr_n <= p0 - p1;
                end else begin
                  fr_neg <= bneg; fr_n <= p1 - p0;
                end
              end
            end
            default: begin
              fr_d   <= p2;
              which  <= 2'd2;
              state  <= S_GINIT;
              fr_neg <= fa_neg ^ fb_neg;
              fr_n   <= p0;
            end
          endcase
        end
        S_CHK: begin
          state <= S_OUT;
          if (st != ST_OK || act == ACT_CMP) begin
            onum <= 32'd0; oden <= 31'd1;
          end else begin
            // result of a normalize sits in fa; others in fr
            logic        rn;
            logic [63:0] nn, dd;
            rn = (act == ACT_NORM) ? fa_neg : fr_neg;
            nn = (act == ACT_NORM) ? fa_n : fr_n;
            dd = (act == ACT_NORM) ? fa_d : fr_d;
            if (nn > Lim || dd > Lim) begin
              st <= ST_OVFL; onum <= 32'd0; oden <= 31'd1;
            end else begin
              onum <= rn ? (~nn[31:0] + 32'd1) : nn[31:0];
              oden <= dd[30:0];
            end
          end
        end
        S_OUT: begin
          m_axis_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign mprod = {32'd0, mx} * {32'd0, my};

  `RAU_ASSERT_IMP(a_ready_idle, s_axis_tready, state == S_IDLE)
  `RAU_ASSERT_NEXT(a_accept_load, s_axis_tvalid && s_axis_tready, state == S_LOAD)
  `RAU_ASSERT_IMP(a_valid_den, m_axis_tvalid, oden != 31'd0)
  `RAU_ASSERT_IMP(a_err_zero, m_axis_tvalid && st != ST_OK, onum == 32'd0 && ord == 2'd0)
endmodule

@@ tb/sv/rational_arithmetic_unit_test.sv @@
// ---------------------------------------------------------------------------
// rational arithmetic unit testbench
// drives fraction operations with random gaps and back-pressure, predicts
// every reduced result and compares each result transaction field by field
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module rational_arithmetic_unit_test;
  import rau_pkg::*;

  // last member sits in the lowest bits
  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] b_den;
    logic [31:0] b_num;
    logic [31:0] a_den;
    logic [31:0] a_num;
  } op_item_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  order;
    logic [30:0] res_den;
    logic [31:0] res_num;
  } frac_result_t;

  localparam int unsigned CycleLimit = 6000000;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [71:0]  m_axis_tdata;

  op_item_t     pending_ops[$];
  frac_result_t expected_results[$];
  int           mismatches;
  int           checked;
  int unsigned  cycle_count;
  bit           sender_hold;
  bit           calm_window;
  int           stall_left;
  bit           stall_request;
  int           op_counts[8];

  rational_arithmetic_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic void split_word(logic [31:0] v, output bit neg,
                                     output logic [63:0] mag);
    neg = v[31];
    mag = v[31] ? 64'(-{1'b1, v}) & 64'hFFFF_FFFF : 64'(v);
    if (v == 32'h8000_0000) mag = 64'h8000_0000;
  endfunction

  function automatic void reduce(bit neg, logic [63:0] n, logic [63:0] d,
                                 output bit rneg, output logic [63:0] rn,
                                 output logic [63:0] rd);
    logic [63:0] g;
    if (n == 0) begin
      rneg = 0; rn = 0; rd = 1;
    end else begin
      g = gcd64(n, d);
      rneg = neg; rn = n / g; rd = d / g;
    end
  endfunction

  function automatic void signed_sum(bit n1, logic [63:0] m1, bit n2, logic [63:0] m2,
                                     output bit rneg, output logic [63:0] rm);
    if (n1 == n2) begin
      rneg = n1; rm = m1 + m2;
    end else if (m1 >= m2) begin
      rneg = n1; rm = m1 - m2;
    end else begin
      rneg = n2; rm = m2 - m1;
    end
  endfunction

  function automatic frac_result_t predict_fraction(op_item_t op);
    frac_result_t r;
    logic [2:0]   act;
    bit           sn, sd, an, bn, neg, rneg, bneg;
    logic [63:0]  mn, md, a_n, a_d, b_n, b_d, n, d, rn, rd;
    logic [63:0]  lim;
    lim = 64'h7FFF_FFFF;
    act = (op.action > ACT_CMP) ? ACT_NORM : op.action;
    r = '{res_num: 0, res_den: 1, order: 0, status: ST_OK};
    if (op.a_den == 0 || (act != ACT_NORM && op.b_den == 0)) begin
      r.status = ST_ZDEN;
      return r;
    end
    split_word(op.a_num, sn, mn);
    split_word(op.a_den, sd, md);
    reduce(sn != sd, mn, md, an, a_n, a_d);
    split_word(op.b_num, sn, mn);
    split_word(op.b_den, sd, md);
    reduce(sn != sd, mn, md, bn, b_n, b_d);
    case (act)
      ACT_ADD, ACT_SUB: begin
        bneg = (act == ACT_SUB && b_n != 0) ? !bn : bn;
        signed_sum(an, a_n * b_d, bneg, b_n * a_d, neg, n);
        d = a_d * b_d;
      end
      ACT_MUL: begin
        neg = an != bn; n = a_n * b_n; d = a_d * b_d;
      end
      ACT_DIV: begin
        if (b_n == 0) begin
          r.status = ST_DIVZ;
          return r;
        end
        neg = an != bn; n = a_n * b_d; d = a_d * b_n;
      end
      ACT_CMP: begin
        signed_sum(an, a_n * b_d, (b_n != 0) ? !bn : 1'b0, b_n * a_d, neg, n);
        r.order = (n == 0) ? 2'd0 : (neg ? 2'b11 : 2'd1);
        return r;
      end
      default: begin
        neg = an; n = a_n; d = a_d;
      end
    endcase
    reduce(neg, n, d, rneg, rn, rd);
    if (rn > lim || rd > lim) begin
      r.status = ST_OVFL;
      return r;
    end
    r.res_num = rneg ? 32'(-rn) : 32'(rn);
    r.res_den = 31'(rd);
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(int'($urandom_range(0, 6)) - 3);
      3, 4, 5: return 32'(int'($urandom_range(0, 400)) - 200);
      6, 7: return 32'(int'($urandom_range(0, 131072)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(logic [2:0] act, logic [31:0] an, logic [31:0] ad,
                          logic [31:0] bn, logic [31:0] bd);
    pending_ops.push_back('{action: act, a_num: an, a_den: ad, b_num: bn, b_den: bd});
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        expected_results.push_back(predict_fraction(pending_ops[0]));
        op_counts[pending_ops[0].action]++;
        void'(pending_ops.pop_front());
      end
      if (pending_ops.size() > 0 && !sender_hold &&
          (calm_window || $urandom_range(0, 99) >= 17)) begin
        s_axis_tvalid <= 1'b1;
        {s_axis_tuser, s_axis_tdata} <= pending_ops[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    frac_result_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = frac_result_t'(m_axis_tdata[66:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (got.res_num !== want.res_num)
            $display("%0t: res_num expected %0d actual %0d", $time,
                     $signed(want.res_num), $signed(got.res_num));
          if (got.res_den !== want.res_den)
            $display("%0t: res_den expected %0d actual %0d", $time,
                     want.res_den, got.res_den);
          if (got.order !== want.order)
            $display("%0t: order expected %0d actual %0d", $time,
                     $signed(want.order), $signed(got.order));
          if (got.status !== want.status)
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, got.status);
          if (got !== want) mismatches++;
        end
      end
      if (stall_request && stall_left == 0) begin
        stall_left <= 3000;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= (stall_left == 1);
      end else begin
        m_axis_tready <= calm_window || $urandom_range(0, 99) >= 17;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [31:0] ext[4];
    int          idx;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    mismatches = 0;
    checked = 0;
    cycle_count = 0;
    sender_hold = 0;
    calm_window = 0;
    stall_request = 0;
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: every action, zero denominators, zero divisor, overflow, extremes
    for (int a = 0; a < 8; a++) queue_op(3'(a), 6, -4, 3, 9);
    queue_op(ACT_NORM, 5, 0, 0, 0);
    queue_op(ACT_ADD, 1, 2, 1, 0);
    queue_op(ACT_NORM, 0, -7, 0, 0);
    queue_op(ACT_DIV, 1, 2, 0, 5);
    queue_op(ACT_NORM, 32'h8000_0000, 1, 0, 0);
    queue_op(ACT_NORM, 32'h8000_0000, 32'h8000_0000, 0, 0);
    queue_op(ACT_MUL, 32'h7FFF_FFFF, 1, 2, 1);
    queue_op(ACT_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 1, 32'h7FFF_FFFD);
    queue_op(ACT_SUB, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1);
    queue_op(ACT_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_op(ACT_CMP, 1, 3, 2, 6);
    queue_op(ACT_CMP, -1, 3, 1, -3);
    queue_op(ACT_CMP, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1);
    for (int k = 0; k < 4; k++)
      queue_op(ACT_MUL, ext[k], ext[(k + 1) % 4], ext[(k + 2) % 4], ext[(k + 3) % 4]);

    // long receiver stall while the sender keeps offering
    wait (pending_ops.size() < 20);
    stall_request = 1;
    wait (stall_left > 0);
    stall_request = 0;

    for (int i = 0; i < 1550; i++) begin
      idx = $urandom_range(0, 99);
      queue_op(idx < 4 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5)),
               pick_word(), $urandom_range(0, 40) == 0 ? 32'd0 : pick_word(),
               pick_word(), $urandom_range(0, 40) == 0 ? 32'd0 : pick_word());
      if (i == 500) begin
        wait (pending_ops.size() == 0);
        sender_hold = 1;
        wait (expected_results.size() == 0 && !s_axis_tvalid);
        sender_hold = 0;
        calm_window = 1;
      end
      if (i == 700) calm_window = 0;
    end

    wait (pending_ops.size() == 0 && !s_axis_tvalid);
    wait (expected_results.size() == 0);
    repeat (600) @(posedge clk);
    $display("checked %0d results; per action norm %0d add %0d sub %0d mul %0d",
             checked, op_counts[0] + op_counts[6] + op_counts[7], op_counts[1],
             op_counts[2], op_counts[3]);
    $display("div %0d cmp %0d, incl. zero denominators, extremes and stalls",
             op_counts[4], op_counts[5]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
